@@ rtl/fba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types, codes and constants of the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int NUM_FRAMES_DEF = 4096;
  localparam int FRAME_W        = 12;
  localparam int PERM_W         = 4;
  localparam int STATUS_W       = 2;
  localparam int OPCODE_W       = 2;
  localparam int WORD_BITS      = 32;
  localparam int BIT_W          = 5;
  localparam int WORD_IDX_W     = FRAME_W - BIT_W;
  localparam int FIELD_WORDS    = (1 << FRAME_W) / WORD_BITS;
  localparam int Q_DEPTH        = 2;

  localparam logic [PERM_W-1:0] PERM_WRITE = 4'h8;
  localparam logic [PERM_W-1:0] PERM_EXEC  = 4'h4;

  localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RESERVE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_TEST    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOP  = 2'd2;

  // what the back end has to do with an item
  localparam logic [2:0] K_REPLY = 3'd0;
  localparam logic [2:0] K_ALLOC = 3'd1;
  localparam logic [2:0] K_CLR   = 3'd2;
  localparam logic [2:0] K_SET   = 3'd3;
  localparam logic [2:0] K_TEST  = 3'd4;

  typedef struct packed {
    logic [2:0]            kind;
    logic [WORD_IDX_W-1:0] word;
    logic [BIT_W-1:0]      bitpos;
    logic [FRAME_W-1:0]    res_frame;
    logic [PERM_W-1:0]     res_perm;
    logic [PERM_W-1:0]     alloc_perm;
    logic [STATUS_W-1:0]   res_status;
  } cmd_t;

  // bitmap words actually kept: whole words only, and only 12-bit frames
  function automatic int words_kept(input int num_frames);
    int w;
    begin
      w = num_frames / WORD_BITS;
      words_kept = (w < FIELD_WORDS) ? w : FIELD_WORDS;
    end
  endfunction

  function automatic int addr_width(input int depth);
    begin
      addr_width = (depth > 1) ? $clog2(depth) : 1;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/fba_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [fba_pkg::addr_width(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [fba_pkg::addr_width(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/fba_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fba_front
// Accepts items, classifies them and queues the resulting commands.
// ----------------------------------------------------------------------------
module fba_front #(
  parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic                             hold,
  input  wire logic [fba_pkg::OPCODE_W-1:0]     opcode,
  input  wire logic [fba_pkg::FRAME_W-1:0]      frame_index,
  input  wire logic [fba_pkg::FRAME_W-1:0]      current_frame,
  input  wire logic [fba_pkg::PERM_W-1:0]       perm_in,
  input  wire logic                             writeable,
  input  wire logic                             executable,
  input  wire logic                             pop,
  output logic                                  full,
  output logic                                  q_valid,
  output fba_pkg::cmd_t                         head
);

  localparam int USED_WORDS = fba_pkg::words_kept(NUM_FRAMES);
  localparam int PW = fba_pkg::addr_width(fba_pkg::Q_DEPTH);
  localparam int CW = $clog2(fba_pkg::Q_DEPTH + 1);

  fba_pkg::cmd_t  cmd;
  fba_pkg::cmd_t  queue [fba_pkg::Q_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic [fba_pkg::FRAME_W-1:0] target;
  logic           in_map;

  assign full    = (count == CW'(fba_pkg::Q_DEPTH));
  assign q_valid = (count != '0);
  assign push    = start && !full && !hold;
  assign head    = queue[rd_ptr];

  // free works on the page's own frame, reserve and test on frame_index
  assign target = (opcode == fba_pkg::OP_FREE) ? current_frame : frame_index;
  assign in_map = ({1'b0, target[fba_pkg::FRAME_W-1:fba_pkg::BIT_W]}
                   < (fba_pkg::WORD_IDX_W + 1)'(USED_WORDS));

  always_comb begin
    cmd            = '0;
    cmd.word       = target[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
    cmd.bitpos     = target[fba_pkg::BIT_W-1:0];
    cmd.res_frame  = current_frame;
    cmd.res_perm   = perm_in;
    cmd.alloc_perm = perm_in | (writeable ? fba_pkg::PERM_WRITE : '0)
                             | (executable ? fba_pkg::PERM_EXEC : '0);
    cmd.res_status = fba_pkg::ST_DONE;
    cmd.kind       = fba_pkg::K_REPLY;
    unique case (opcode)
      fba_pkg::OP_ALLOC: begin
        if (current_frame != '0) begin
          cmd.res_status = fba_pkg::ST_NOP;
        end else begin
          cmd.kind      = fba_pkg::K_ALLOC;
          cmd.res_frame = '0;
        end
      end
      fba_pkg::OP_FREE: begin
        cmd.res_frame = '0;
        if (current_frame == '0) begin
          cmd.res_status = fba_pkg::ST_NOP;
        end else if (in_map) begin
          cmd.kind = fba_pkg::K_CLR;
        end
      end
      fba_pkg::OP_RESERVE: begin
        if (in_map) begin
          cmd.kind = fba_pkg::K_SET;
        end
      end
      fba_pkg::OP_TEST: begin
        if (in_map) begin
          cmd.kind = fba_pkg::K_TEST;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(fba_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(fba_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd;
    end
  end

  ap_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(fba_pkg::Q_DEPTH))
    else $error("queue count out of range");

  ap_no_push_in_hold: assert property (@(posedge clk) disable iff (rst)
    hold |=> $stable(wr_ptr))
    else $error("item queued while bitmap is being cleared");

endmodule
`default_nettype wire

@@ rtl/fba_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fba_back
// Executes queued commands: direct replies and, on the bitmap RAM, read-modify-write,
// test, first-fit scan, and the clearing pass after reset.
// ----------------------------------------------------------------------------
module fba_back #(
  parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 q_valid,
  input  wire fba_pkg::cmd_t                        head,
  output logic                                      pop,
  output logic                                      clearing,
  output logic                                      we,
  output logic [fba_pkg::addr_width(fba_pkg::words_kept(NUM_FRAMES))-1:0] waddr,
  output logic [fba_pkg::WORD_BITS-1:0]             wdata,
  output logic [fba_pkg::addr_width(fba_pkg::words_kept(NUM_FRAMES))-1:0] raddr,
  input  wire logic [fba_pkg::WORD_BITS-1:0]        rdata,
  output logic                                      done,
  output logic [fba_pkg::FRAME_W-1:0]               frame_out,
  output logic [fba_pkg::PERM_W-1:0]                perm_out,
  output logic [fba_pkg::STATUS_W-1:0]              status,
  output logic                                      frame_used
);

  localparam int USED_WORDS = fba_pkg::words_kept(NUM_FRAMES);
  localparam int AW = fba_pkg::addr_width(USED_WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(USED_WORDS - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RMW   = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0]          state, state_next;
  logic [AW-1:0]       clr_cnt, clr_cnt_next;
  logic [AW-1:0]       scan_word, scan_word_next;
  fba_pkg::cmd_t       cmd, cmd_next;
  logic                emit;
  logic [fba_pkg::FRAME_W-1:0]   e_frame;
  logic [fba_pkg::PERM_W-1:0]    e_perm;
  logic [fba_pkg::STATUS_W-1:0]  e_status;
  logic                          e_used;
  logic [fba_pkg::WORD_BITS-1:0] mask;
  logic [fba_pkg::BIT_W-1:0]     zero_pos;

  function automatic logic [fba_pkg::BIT_W-1:0] lowest_zero(
    input logic [fba_pkg::WORD_BITS-1:0] v);
    logic [fba_pkg::BIT_W-1:0] idx;
    begin
      idx = '0;
      for (int i = fba_pkg::WORD_BITS - 1; i >= 0; i--) begin
        if (!v[i]) begin
          idx = fba_pkg::BIT_W'(i);
        end
      end
      lowest_zero = idx;
    end
  endfunction

  assign clearing = (state == S_CLEAR);
  assign mask     = fba_pkg::WORD_BITS'(1) << cmd.bitpos;
  assign zero_pos = lowest_zero(rdata);

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    scan_word_next = scan_word;
    cmd_next       = cmd;
    pop            = 1'b0;
    we             = 1'b0;
    waddr          = cmd.word[AW-1:0];
    wdata          = rdata;
    raddr          = head.word[AW-1:0];
    emit           = 1'b0;
    e_frame        = cmd.res_frame;
    e_perm         = cmd.res_perm;
    e_status       = cmd.res_status;
    e_used         = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_cnt;
        wdata        = '0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          cmd_next = head;
          priority case (head.kind)
            fba_pkg::K_ALLOC: begin
              raddr          = '0;
              scan_word_next = '0;
              state_next     = S_SCAN;
            end
            fba_pkg::K_CLR, fba_pkg::K_SET, fba_pkg::K_TEST: begin
              state_next = S_RMW;
            end
            default: begin
              // answered without touching the bitmap
              emit     = 1'b1;
              e_frame  = head.res_frame;
              e_perm   = head.res_perm;
              e_status = head.res_status;
            end
          endcase
        end
      end
      S_RMW: begin
        emit       = 1'b1;
        state_next = S_IDLE;
        priority case (cmd.kind)
          fba_pkg::K_SET: begin
            we    = 1'b1;
            wdata = rdata | mask;
          end
          fba_pkg::K_CLR: begin
            we    = 1'b1;
            wdata = rdata & ~mask;
          end
          default: begin
            e_used = |(rdata & mask);
          end
        endcase
      end
      S_SCAN: begin
        // rdata holds word scan_word; the next word is fetched meanwhile
        if (rdata != '1) begin
          we         = 1'b1;
          waddr      = scan_word;
          wdata      = rdata | (fba_pkg::WORD_BITS'(1) << zero_pos);
          emit       = 1'b1;
          e_frame    = fba_pkg::FRAME_W'({scan_word, zero_pos});
          e_perm     = cmd.alloc_perm;
          e_status   = fba_pkg::ST_DONE;
          state_next = S_IDLE;
        end else if (scan_word == LAST_WORD) begin
          emit       = 1'b1;
          e_frame    = '0;
          e_status   = fba_pkg::ST_FULL;
          state_next = S_IDLE;
        end else begin
          raddr          = scan_word + 1'b1;
          scan_word_next = scan_word + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      done    <= emit;
    end
  end

  always_ff @(posedge clk) begin
    scan_word <= scan_word_next;
    cmd       <= cmd_next;
    if (emit) begin
      frame_out  <= e_frame;
      perm_out   <= e_perm;
      status     <= e_status;
      frame_used <= e_used;
    end
  end

  ap_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("command taken during clearing pass");

  ap_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

  ap_done_back_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result issued while command still running");

  ap_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_word <= LAST_WORD)
    else $error("scan beyond last bitmap word");

endmodule
`default_nettype wire

@@ rtl/frame_bitmap_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit physical frame allocator over a one-bit-per-frame bitmap.
// ----------------------------------------------------------------------------
// Items needing no bitmap access (nothing to do, or a frame beyond the bitmap)
// are answered as they are taken from the queue, other free/reserve/test after
// a read of their word, and alloc after a first-fit scan of up to W bitmap words
// (W = NUM_FRAMES/32, at most 128) that reads one bitmap word per cycle.
// A two-entry command queue takes new items while one executes; busy rises
// when it is full. After reset busy stays high while the bitmap RAM is zeroed,
// one word per cycle. Results cannot be stalled.
module frame_bitmap_allocator #(
  parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [fba_pkg::OPCODE_W-1:0]  opcode,
  input  wire logic [fba_pkg::FRAME_W-1:0]   frame_index,
  input  wire logic [fba_pkg::FRAME_W-1:0]   current_frame,
  input  wire logic [fba_pkg::PERM_W-1:0]    perm_in,
  input  wire logic                          writeable,
  input  wire logic                          executable,
  output logic                               done,
  output logic [fba_pkg::FRAME_W-1:0]        frame_out,
  output logic [fba_pkg::PERM_W-1:0]         perm_out,
  output logic [fba_pkg::STATUS_W-1:0]       status,
  output logic                               frame_used
);

  localparam int USED_WORDS = fba_pkg::words_kept(NUM_FRAMES);
  localparam int AW = fba_pkg::addr_width(USED_WORDS);

  logic          full;
  logic          q_valid;
  logic          pop;
  logic          clearing;
  fba_pkg::cmd_t head;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [fba_pkg::WORD_BITS-1:0] wdata;
  logic [fba_pkg::WORD_BITS-1:0] rdata;

  assign busy = full | clearing;

  fba_front #(.NUM_FRAMES(NUM_FRAMES)) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .hold          (clearing),
    .opcode        (opcode),
    .frame_index   (frame_index),
    .current_frame (current_frame),
    .perm_in       (perm_in),
    .writeable     (writeable),
    .executable    (executable),
    .pop           (pop),
    .full          (full),
    .q_valid       (q_valid),
    .head          (head)
  );

  fba_back #(.NUM_FRAMES(NUM_FRAMES)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr      (raddr),
    .rdata      (rdata),
    .done       (done),
    .frame_out  (frame_out),
    .perm_out   (perm_out),
    .status     (status),
    .frame_used (frame_used)
  );

  fba_ram #(
    .WIDTH (fba_pkg::WORD_BITS),
    .DEPTH (USED_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule
`default_nettype wire
